// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker module of the boot command detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Same-cycle implication that is also checked across reset.
`define ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("check failed");

`endif

// ----- rtl/core/ebcd_pkg.sv -----
// Types and constants of the eMMC boot command detector.
package ebcd_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned SHIFT_W = 5;

  localparam logic [WORD_W-1:0] IDLE_WORD = 32'hffff_ffff;

  localparam logic [WORD_W-1:0] GO_IDLE_A = 32'h4000_0000;
  localparam logic [WORD_W-1:0] GO_IDLE_B = 32'h0095_ffff;
  localparam logic [WORD_W-1:0] PRE_IDLE_A = 32'h40f0_f0f0;
  localparam logic [WORD_W-1:0] PRE_IDLE_B = 32'hf0fd_ffff;
  localparam logic [WORD_W-1:0] BOOT_INIT_A = 32'h40ff_ffff;
  localparam logic [WORD_W-1:0] BOOT_INIT_B = 32'hfae5_ffff;

  typedef enum logic [1:0] {
    CMD_GO_IDLE     = 2'd0,
    CMD_GO_PRE_IDLE = 2'd1,
    CMD_BOOT_INIT   = 2'd2,
    CMD_UNKNOWN     = 2'd3
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t command_code;
    logic      start_transfer;
    logic      stop_transfer;
    logic      transmitting;
  } result_t;

endpackage

// ----- rtl/core/ebcd_in_if.sv -----
// Input channel carrying one sampled CMD line word per beat.
interface ebcd_in_if;
  import ebcd_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] rx_word;

  modport source (output valid, output rx_word, input ready);
  modport sink (input valid, input rx_word, output ready);
endinterface

// ----- rtl/core/ebcd_out_if.sv -----
// Output channel carrying one detected command result per beat.
interface ebcd_out_if;
  import ebcd_pkg::*;

  logic      valid;
  logic      ready;
  cmd_code_t command_code;
  logic      start_transfer;
  logic      stop_transfer;
  logic      transmitting;

  modport source (output valid, output command_code, output start_transfer,
                  output stop_transfer, output transmitting, input ready);
  modport sink (input valid, input command_code, input start_transfer,
                input stop_transfer, input transmitting, output ready);
endinterface

// ----- rtl/core/emmc_boot_command_detector_unit.sv -----
// Top level of the eMMC boot command detector.
// A result appears in the cycle after the beat of the idle word that ends a command.
// Throughput: one input beat per cycle unless the output stalls; the history shift and the
// single result register set that figure, and a new word is taken while a result waits
// if it is taken. Reset: synchronous; the word history returns to idle, the transmit flag
// and the output valid clear.
module emmc_boot_command_detector_unit (
  input logic clk,
  input logic rst,
  ebcd_in_if.sink    rx,
  ebcd_out_if.source cmd
);
  import ebcd_pkg::*;

  logic [WORD_W-1:0]    word_history [3];
  logic                 sending;
  logic                 sending_next;
  logic                 out_valid;
  result_t              out_data;
  result_t              result_next;

  logic                 accept;
  logic                 detect;
  logic [WORD_W-1:0]    f0;
  logic [WORD_W-1:0]    f1;
  logic [WORD_W-1:0]    f2;
  logic [SHIFT_W-1:0]   sh;
  logic [3*WORD_W-1:0]  shifted;
  logic [WORD_W-1:0]    a;
  logic [WORD_W-1:0]    b;
  cmd_code_t            code;

  assign rx.ready = !out_valid || cmd.ready;
  assign accept = rx.valid && rx.ready;
  assign detect = (rx.rx_word == IDLE_WORD) && (word_history[2] != IDLE_WORD);

  always_comb begin
    if (word_history[0] == IDLE_WORD) begin
      f0 = word_history[1];
      f1 = word_history[2];
      f2 = rx.rx_word;
    end else begin
      f0 = word_history[0];
      f1 = word_history[1];
      f2 = word_history[2];
    end
  end

  // The highest zero bit of the first word marks the start bit.
  always_comb begin
    sh = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (!f0[i]) begin
        sh = SHIFT_W'(WORD_W - 1 - i);
      end
    end
  end

  assign shifted = {f0, f1, f2} << sh;
  assign a = shifted[3*WORD_W-1:2*WORD_W];
  assign b = shifted[2*WORD_W-1:WORD_W];

  always_comb begin
    priority if (f0 == IDLE_WORD) begin
      code = CMD_UNKNOWN;
    end else if (a == GO_IDLE_A && b == GO_IDLE_B) begin
      code = CMD_GO_IDLE;
    end else if (a == PRE_IDLE_A && b == PRE_IDLE_B) begin
      code = CMD_GO_PRE_IDLE;
    end else if (a == BOOT_INIT_A && b == BOOT_INIT_B) begin
      code = CMD_BOOT_INIT;
    end else begin
      code = CMD_UNKNOWN;
    end
  end

  always_comb begin
    sending_next = sending;
    result_next.command_code = code;
    result_next.start_transfer = 1'b0;
    result_next.stop_transfer = 1'b0;
    if (!sending) begin
      if (code == CMD_BOOT_INIT) begin
        sending_next = 1'b1;
        result_next.start_transfer = 1'b1;
      end
    end else if (code == CMD_GO_IDLE || code == CMD_GO_PRE_IDLE) begin
      sending_next = 1'b0;
      result_next.stop_transfer = 1'b1;
    end
    result_next.transmitting = sending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_history[0] <= IDLE_WORD;
      word_history[1] <= IDLE_WORD;
      word_history[2] <= IDLE_WORD;
      sending <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        word_history[0] <= word_history[1];
        word_history[1] <= word_history[2];
        word_history[2] <= rx.rx_word;
        if (detect) begin
          sending <= sending_next;
        end
      end
      if (accept && detect) begin
        out_valid <= 1'b1;
      end else if (cmd.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && detect) begin
      out_data <= result_next;
    end
  end

  assign cmd.valid = out_valid;
  assign cmd.command_code = out_data.command_code;
  assign cmd.start_transfer = out_data.start_transfer;
  assign cmd.stop_transfer = out_data.stop_transfer;
  assign cmd.transmitting = out_data.transmitting;

endmodule

// ----- rtl/core/ebcd_checker.sv -----
// Port-level checker for the eMMC boot command detector and its bind.
`include "assert_macros.svh"

module ebcd_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input ebcd_pkg::cmd_code_t command_code,
  input logic                start_transfer,
  input logic                stop_transfer,
  input logic                transmitting
);
  import ebcd_pkg::*;

  `ASSERT_IMPLIES(start_means_boot, clk, rst, out_valid && start_transfer, command_code == CMD_BOOT_INIT && transmitting && !stop_transfer)
  `ASSERT_IMPLIES(stop_means_idle, clk, rst, out_valid && stop_transfer, !transmitting && (command_code == CMD_GO_IDLE || command_code == CMD_GO_PRE_IDLE))
  `ASSERT_NEXT(stall_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(command_code) && $stable(transmitting))
  `ASSERT_ALWAYS(empty_after_reset, clk, $past(rst), !out_valid)

endmodule

bind emmc_boot_command_detector_unit ebcd_checker u_ebcd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (cmd.valid),
  .out_ready      (cmd.ready),
  .command_code   (cmd.command_code),
  .start_transfer (cmd.start_transfer),
  .stop_transfer  (cmd.stop_transfer),
  .transmitting   (cmd.transmitting)
);
